>>> sv/rscr_pkg.sv
// Shared constants, types and the cosine table for the range scan column raster.
`timescale 1ns / 1ps

package rscr_pkg;

    // Sizing
    localparam int MAX_BEAMS      = 1024;
    localparam int COS_TABLE_SIZE = 1024;

    localparam int BEAM_AW = $clog2(MAX_BEAMS);
    localparam int COUNT_W = $clog2(MAX_BEAMS + 1);
    localparam int COS_AW  = $clog2(COS_TABLE_SIZE);

    // Field widths
    localparam int RANGE_W    = 16;
    localparam int ANGLE_W    = 10;
    localparam int HEIGHT_W   = 13;
    localparam int ROW_W      = 12;
    localparam int COL_W      = 10;
    localparam int PIXEL_W    = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Arithmetic formats
    localparam int COS_W       = 16;  // Q1.15
    localparam int NORM_W      = 17;  // signed Q.16 normalized range
    localparam int VALUE_W     = 18;  // signed Q2.16 stored value
    localparam int NORM_SHIFT  = 16;
    localparam int VALUE_SHIFT = 15;
    localparam int ROW_SHIFT   = 16;
    localparam int QPROD_W     = VALUE_W + HEIGHT_W + 1;

    // Commands
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_MIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_MAX  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INV_SPAN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_START_ANG  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT     = 3'd5;

    localparam logic [PIXEL_W-1:0] PIXEL_DARK  = 8'd0;
    localparam logic [PIXEL_W-1:0] PIXEL_BLANK = 8'd255;

    // Memory access request from the sequencer
    typedef struct packed {
        logic                      wr_en;
        logic [BEAM_AW-1:0]        wr_addr;
        logic signed [VALUE_W-1:0] wr_value;
        logic                      wr_at_max;
        logic                      rd_en;
        logic [BEAM_AW-1:0]        rd_addr;
    } t_mem_req;

    typedef logic signed [COS_W-1:0] t_cos_tab [COS_TABLE_SIZE];
    typedef longint unsigned t_u64;

    localparam longint Q30_ONE     = 64'sd1073741824;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;

    // cos(pi/2 * r / COS_TABLE_SIZE) in Q30, degree-8 Taylor, elaboration only
    function automatic longint quarter_cos_q30(longint r);
        longint x;
        longint x2;
        longint t;
        x  = HALF_PI_Q30 * r / COS_TABLE_SIZE;
        x2 = longint'(t_u64'(x * x) >> 30);
        t  = Q30_ONE - x2 / 56;
        t  = Q30_ONE - longint'(t_u64'(x2 * t) >> 30) / 30;
        t  = Q30_ONE - longint'(t_u64'(x2 * t) >> 30) / 12;
        t  = Q30_ONE - longint'(t_u64'(x2 * t) >> 30) / 2;
        return t;
    endfunction

    function automatic t_cos_tab build_cos_tab();
        t_cos_tab tab;
        longint   u;
        longint   quad;
        longint   r;
        longint   c;
        for (int k = 0; k < COS_TABLE_SIZE; k++) begin
            u    = 4 * longint'(k);
            quad = u / COS_TABLE_SIZE;
            r    = u % COS_TABLE_SIZE;
            if (quad == 0) begin
                c = quarter_cos_q30(r);
            end else if (quad == 1) begin
                c = -quarter_cos_q30(COS_TABLE_SIZE - r);
            end else if (quad == 2) begin
                c = -quarter_cos_q30(r);
            end else begin
                c = quarter_cos_q30(COS_TABLE_SIZE - r);
            end
            c = (c + 64'sd16384) >>> 15;
            if (c > 32767) begin
                c = 32767;
            end
            if (c < -32767) begin
                c = -32767;
            end
            tab[k] = COS_W'(c);
        end
        return tab;
    endfunction

    localparam t_cos_tab COS_TAB = build_cos_tab();

    // Table entry for a 10-bit angle: (angle * size) >> 10
    function automatic logic [COS_AW-1:0] cos_index(logic [ANGLE_W-1:0] ang);
        logic [ANGLE_W+COS_AW-1:0] p;
        p = (ANGLE_W + COS_AW)'(ang) * (ANGLE_W + COS_AW)'(COS_TABLE_SIZE);
        return p[ANGLE_W+COS_AW-1:ANGLE_W];
    endfunction

endpackage

>>> sv/rscr_cos_rom.sv
// Cosine lookup ROM with registered read.
`timescale 1ns / 1ps

module rscr_cos_rom (
    input  logic                              i_clk,
    input  logic [rscr_pkg::COS_AW-1:0]       i_addr,
    output logic signed [rscr_pkg::COS_W-1:0] o_data
);
    import rscr_pkg::*;

    logic signed [COS_W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        r_data <= COS_TAB[i_addr];
    end

    assign o_data = r_data;

endmodule

>>> sv/rscr_load_path.sv
// Beam value pipeline: range normalization and cosine scaling.
`timescale 1ns / 1ps

module rscr_load_path (
    input  logic                                i_clk,
    input  logic [rscr_pkg::RANGE_W-1:0]        i_range_mm,
    input  logic [rscr_pkg::RANGE_W-1:0]        i_range_min,
    input  logic [rscr_pkg::RANGE_W-1:0]        i_inv_span,
    input  logic [rscr_pkg::ANGLE_W-1:0]        i_angle,
    output logic signed [rscr_pkg::VALUE_W-1:0] o_value
);
    import rscr_pkg::*;

    logic signed [RANGE_W:0]          diff;
    logic signed [2*RANGE_W+1:0]      r_prod1;
    logic signed [NORM_W-1:0]         norm;
    logic signed [COS_W-1:0]          cos_q;
    logic signed [NORM_W+COS_W-1:0]   r_prod2;

    assign diff = $signed({1'b0, i_range_mm}) - $signed({1'b0, i_range_min});

    rscr_cos_rom u_cos_rom (
        .i_clk  (i_clk),
        .i_addr (cos_index(i_angle)),
        .o_data (cos_q)
    );

    // stage 1: diff * reciprocal span, cosine fetched alongside
    always_ff @(posedge i_clk) begin
        r_prod1 <= diff * $signed({1'b0, i_inv_span});
    end

    // floor(prod / 2^16); |prod| < 2^32 so 17 bits hold it
    assign norm = r_prod1[NORM_SHIFT+NORM_W-1:NORM_SHIFT];

    // stage 2: scale by cosine
    always_ff @(posedge i_clk) begin
        r_prod2 <= norm * cos_q;
    end

    // floor(prod / 2^15); magnitude stays below 2^16, inside Q2.16, so
    // no saturation is needed
    assign o_value = r_prod2[VALUE_SHIFT+VALUE_W-1:VALUE_SHIFT];

endmodule

>>> sv/rscr_beam_mem.sv
// Beam store: one entry per column, value plus at-max flag.
`timescale 1ns / 1ps

module rscr_beam_mem (
    input  logic                                i_clk,
    input  rscr_pkg::t_mem_req                  i_req,
    output logic signed [rscr_pkg::VALUE_W-1:0] o_rd_value,
    output logic                                o_rd_at_max
);
    import rscr_pkg::*;

    logic [VALUE_W:0] r_mem [MAX_BEAMS];
    logic [VALUE_W:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= {i_req.wr_at_max, i_req.wr_value};
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_value  = r_rd_data[VALUE_W-1:0];
    assign o_rd_at_max = r_rd_data[VALUE_W];

endmodule

>>> sv/range_scan_column_raster.sv
// Top level: command sequencer, configuration registers and pixel compare.
//
//  channel   direction  handshake                  payload
//  -------   ---------  -------------------------  -------------------------------------
//  command   in         start & !busy              i_command i_range_mm i_first_beam
//                                                  i_row i_column
//  result    out        o_valid (1-cycle strobe)   o_pixel o_column_invalid
//  config    in         i_cfg_we                   i_cfg_idx i_cfg_data
//
// Load: accept, multiply, write back; no result.
// Query of a loaded column: accept/read, multiply, compare; the result
//   strobes in the cycle after the compare. Query of an unloaded column:
//   answered at the accept, result in the next cycle. The two registered
//   multiply stages and the one-transaction-at-a-time sequencer set these steps.
// Reset (synchronous, active low) clears the sequencer, beam count, angle and
//   configuration; the beam memory is not cleared. The receiver cannot stall.
`timescale 1ns / 1ps

module range_scan_column_raster (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               i_command,
    input  logic [rscr_pkg::RANGE_W-1:0]       i_range_mm,
    input  logic                               i_first_beam,
    input  logic [rscr_pkg::ROW_W-1:0]         i_row,
    input  logic [rscr_pkg::COL_W-1:0]         i_column,
    output logic                               o_valid,
    output logic [rscr_pkg::PIXEL_W-1:0]       o_pixel,
    output logic                               o_column_invalid,
    input  logic                               i_cfg_we,
    input  logic [rscr_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [rscr_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import rscr_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LD_MUL = 3'd1;
    localparam logic [2:0] S_LD_WR  = 3'd2;
    localparam logic [2:0] S_QR_MUL = 3'd3;
    localparam logic [2:0] S_QR_CMP = 3'd4;

    localparam int CMP_W = (COL_W > COUNT_W) ? COL_W : COUNT_W;

    // control state
    logic [2:0]         r_state, n_state;
    logic [COUNT_W-1:0] r_beam_count, n_beam_count;
    logic [ANGLE_W-1:0] r_cur_angle, n_cur_angle;
    logic               r_valid, n_valid;
    logic [PIXEL_W-1:0] r_pixel, n_pixel;
    logic               r_col_inv, n_col_inv;

    // configuration
    logic [RANGE_W-1:0]  r_range_min;
    logic [RANGE_W-1:0]  r_range_max;
    logic [RANGE_W-1:0]  r_inv_span;
    logic [ANGLE_W-1:0]  r_start_angle;
    logic [ANGLE_W-1:0]  r_angle_step;
    logic [HEIGHT_W-1:0] r_height;

    // payload
    logic [BEAM_AW-1:0]        r_wr_addr;
    logic                      r_at_max;
    logic [ROW_W-1:0]          r_row;
    logic signed [QPROD_W-1:0] r_qprod;

    logic                       accept;
    logic                       load_acc;
    logic                       query_acc;
    logic [COUNT_W-1:0]         ld_idx;
    logic [ANGLE_W-1:0]         ld_angle;
    logic                       ld_ok;
    logic                       col_ok;
    logic [COL_W+BEAM_AW-1:0]   col_wide;
    logic signed [VALUE_W-1:0]  ld_value;
    logic signed [VALUE_W-1:0]  rd_value;
    logic                       rd_at_max;
    logic [HEIGHT_W-1:0]        height_eff;
    logic signed [QPROD_W-1:0]  row_scaled;
    logic                       dark;
    t_mem_req                   mem_req;

    assign busy      = (r_state != S_IDLE);
    assign accept    = start && !busy;
    assign load_acc  = accept && (i_command == CMD_LOAD);
    assign query_acc = accept && (i_command == CMD_QUERY);

    // first beam restarts index and angle
    assign ld_idx   = i_first_beam ? '0 : r_beam_count;
    assign ld_angle = i_first_beam ? r_start_angle : r_cur_angle;
    assign ld_ok    = ld_idx < COUNT_W'(MAX_BEAMS);   // full scan drops the load

    // columns at or past the beam count were not loaded in this scan
    assign col_ok   = CMP_W'(i_column) < CMP_W'(r_beam_count);
    assign col_wide = (COL_W + BEAM_AW)'(i_column);

    rscr_load_path u_load_path (
        .i_clk       (i_clk),
        .i_range_mm  (i_range_mm),
        .i_range_min (r_range_min),
        .i_inv_span  (r_inv_span),
        .i_angle     (ld_angle),
        .o_value     (ld_value)
    );

    // writes happen only in S_LD_WR, reads only at a query accept: the
    // sequencer never overlaps them
    always_comb begin
        mem_req.wr_en     = (r_state == S_LD_WR);
        mem_req.wr_addr   = r_wr_addr;
        mem_req.wr_value  = ld_value;
        mem_req.wr_at_max = r_at_max;
        mem_req.rd_en     = query_acc && col_ok;
        mem_req.rd_addr   = col_wide[BEAM_AW-1:0];
    end

    rscr_beam_mem u_beam_mem (
        .i_clk       (i_clk),
        .i_req       (mem_req),
        .o_rd_value  (rd_value),
        .o_rd_at_max (rd_at_max)
    );

    // zero height counts as one
    assign height_eff = (r_height == '0) ? HEIGHT_W'(1) : r_height;

    // row / height < value  <=>  row * 2^16 < value * height
    assign row_scaled = $signed(QPROD_W'({r_row, {ROW_SHIFT{1'b0}}}));
    assign dark       = (row_scaled < r_qprod) || rd_at_max;

    always_comb begin
        n_state      = r_state;
        n_beam_count = r_beam_count;
        n_cur_angle  = r_cur_angle;
        n_valid      = 1'b0;
        n_pixel      = r_pixel;
        n_col_inv    = r_col_inv;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_command == CMD_LOAD) begin
                        if (ld_ok) begin
                            n_state      = S_LD_MUL;
                            n_beam_count = ld_idx + COUNT_W'(1);
                            n_cur_angle  = ld_angle + r_angle_step;
                        end
                    end else if (col_ok) begin
                        n_state = S_QR_MUL;
                    end else begin
                        n_valid   = 1'b1;
                        n_col_inv = 1'b1;
                        n_pixel   = PIXEL_DARK;
                    end
                end
            end
            S_LD_MUL: n_state = S_LD_WR;
            S_LD_WR:  n_state = S_IDLE;
            S_QR_MUL: n_state = S_QR_CMP;
            S_QR_CMP: begin
                n_state   = S_IDLE;
                n_valid   = 1'b1;
                n_col_inv = 1'b0;
                n_pixel   = dark ? PIXEL_DARK : PIXEL_BLANK;
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_beam_count  <= '0;
            r_cur_angle   <= '0;
            r_valid       <= 1'b0;
            r_range_min   <= '0;
            r_range_max   <= '1;
            r_inv_span    <= RANGE_W'(1);
            r_start_angle <= '0;
            r_angle_step  <= ANGLE_W'(1);
            r_height      <= HEIGHT_W'(1);
        end else begin
            r_state      <= n_state;
            r_beam_count <= n_beam_count;
            r_cur_angle  <= n_cur_angle;
            r_valid      <= n_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_RANGE_MIN:  r_range_min   <= i_cfg_data;
                    REG_RANGE_MAX:  r_range_max   <= i_cfg_data;
                    REG_INV_SPAN:   r_inv_span    <= i_cfg_data;
                    REG_START_ANG:  r_start_angle <= i_cfg_data[ANGLE_W-1:0];
                    REG_ANGLE_STEP: r_angle_step  <= i_cfg_data[ANGLE_W-1:0];
                    REG_HEIGHT:     r_height      <= i_cfg_data[HEIGHT_W-1:0];
                    default:        ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pixel   <= n_pixel;
        r_col_inv <= n_col_inv;
        if (load_acc) begin
            r_wr_addr <= ld_idx[BEAM_AW-1:0];
            r_at_max  <= (i_range_mm == r_range_max);
        end
        if (query_acc) begin
            r_row <= i_row;
        end
        if (r_state == S_QR_MUL) begin
            r_qprod <= rd_value * $signed({1'b0, height_eff});
        end
    end

    assign o_valid          = r_valid;
    assign o_pixel          = r_pixel;
    assign o_column_invalid = r_col_inv;

endmodule

>>> sv/rscr_checker.sv
// Port-level checker for the range scan column raster, bound to the top level.
`timescale 1ns / 1ps

module rscr_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         i_command,
    input logic                         o_valid,
    input logic [rscr_pkg::PIXEL_W-1:0] o_pixel,
    input logic                         o_column_invalid
);
    import rscr_pkg::*;

    // reset leaves no result and an idle block
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !busy)
        else $error("result or busy right after reset");

    // pixel is binary
    a_pixel_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_pixel == PIXEL_DARK || o_pixel == PIXEL_BLANK))
        else $error("pixel neither dark nor blank");

    // unloaded column answers dark
    a_invalid_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_column_invalid |-> o_pixel == PIXEL_DARK)
        else $error("invalid column with nonzero pixel");

    // a query either answers at once (unloaded column) or keeps the block busy
    a_query_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_command == CMD_QUERY |=> busy || (o_valid && o_column_invalid))
        else $error("query neither answered nor in progress");

    // a load never produces a result
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_command == CMD_LOAD |=> !o_valid)
        else $error("result strobe after a load");

endmodule

bind range_scan_column_raster rscr_checker u_rscr_checker (.*);

>>> sim/rscr_checker.sv
// Checker for the range scan column raster: pixel prediction and result compare.
`timescale 1ns / 1ps

module rscr_scoreboard
    import rscr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_busy,
    input  logic                  i_command,
    input  logic [RANGE_W-1:0]    i_range_mm,
    input  logic                  i_first_beam,
    input  logic [ROW_W-1:0]      i_row,
    input  logic [COL_W-1:0]      i_column,
    input  logic                  i_valid,
    input  logic [PIXEL_W-1:0]    i_pixel,
    input  logic                  i_column_invalid,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_errors,
    output int                    o_pending
);

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic               column_invalid;
    } t_pixel_answer;

    localparam longint ONE_Q30     = 64'sd1073741824;
    localparam longint QUARTER_Q30 = 64'sd1686629713;  // pi/2 in Q30
    localparam longint VALUE_HI    = 131071;
    localparam longint VALUE_LO    = -131072;

    longint                    cos_q15     [COS_TABLE_SIZE];
    logic signed [VALUE_W-1:0] beam_value  [MAX_BEAMS];
    logic                      beam_blank  [MAX_BEAMS];
    int unsigned               beams_loaded;
    logic [ANGLE_W-1:0]        next_angle;

    logic [RANGE_W-1:0]  cfg_range_min;
    logic [RANGE_W-1:0]  cfg_range_max;
    logic [RANGE_W-1:0]  cfg_inv_span;
    logic [ANGLE_W-1:0]  cfg_start_angle;
    logic [ANGLE_W-1:0]  cfg_angle_step;
    logic [HEIGHT_W-1:0] cfg_height;

    t_pixel_answer pixel_answers_q [$];

    // cos(pi/2 * r / N) in Q30, nested Taylor form, innermost term first
    function automatic longint quarter_wave_q30(longint r);
        longint x;
        longint x_sq;
        longint acc;
        int     divs [4];
        divs = '{56, 30, 12, 2};
        x    = QUARTER_Q30 * r / COS_TABLE_SIZE;
        x_sq = longint'(t_u64'(x * x) >> 30);
        acc  = ONE_Q30;
        foreach (divs[i]) begin
            acc = ONE_Q30 - longint'(t_u64'(x_sq * acc) >> 30) / divs[i];
        end
        return acc;
    endfunction

    initial begin
        longint quad;
        longint rem;
        longint c;
        for (int k = 0; k < COS_TABLE_SIZE; k++) begin
            quad = (4 * longint'(k)) / COS_TABLE_SIZE;
            rem  = (4 * longint'(k)) % COS_TABLE_SIZE;
            case (quad)
                0: c = quarter_wave_q30(rem);
                1: c = -quarter_wave_q30(COS_TABLE_SIZE - rem);
                2: c = -quarter_wave_q30(rem);
                default: c = quarter_wave_q30(COS_TABLE_SIZE - rem);
            endcase
            c = (c + 64'sd16384) >>> 15;
            if (c > 32767) c = 32767;
            if (c < -32767) c = -32767;
            cos_q15[k] = c;
        end
    end

    task automatic store_beam(logic [RANGE_W-1:0] range_mm, logic first);
        int unsigned        slot;
        logic [ANGLE_W-1:0] ang;
        longint             norm;
        longint             val;
        longint             tab_idx;
        slot = first ? 0 : beams_loaded;
        ang  = first ? cfg_start_angle : next_angle;
        if (slot >= MAX_BEAMS) return;  // scan full: dropped
        norm    = ((longint'(range_mm) - longint'(cfg_range_min)) * longint'(cfg_inv_span)) >>> 16;
        tab_idx = (longint'(ang) * COS_TABLE_SIZE) >> ANGLE_W;
        if (tab_idx >= COS_TABLE_SIZE) tab_idx = COS_TABLE_SIZE - 1;
        val = (norm * cos_q15[tab_idx]) >>> 15;
        if (val > VALUE_HI) val = VALUE_HI;
        if (val < VALUE_LO) val = VALUE_LO;
        beam_value[slot] = VALUE_W'(val);
        beam_blank[slot] = (range_mm == cfg_range_max);
        beams_loaded     = slot + 1;
        next_angle       = ang + cfg_angle_step;
    endtask

    function automatic t_pixel_answer predict_pixel(logic [ROW_W-1:0] row,
                                                    logic [COL_W-1:0] col);
        t_pixel_answer a;
        longint        rows;
        a.pixel          = PIXEL_BLANK;
        a.column_invalid = 1'b0;
        if (col >= beams_loaded) begin
            a.pixel          = PIXEL_DARK;
            a.column_invalid = 1'b1;
            return a;
        end
        rows = (cfg_height == 0) ? 1 : longint'(cfg_height);
        if ((longint'(row) * 65536 < longint'(beam_value[col]) * rows) || beam_blank[col]) begin
            a.pixel = PIXEL_DARK;
        end
        return a;
    endfunction

    always @(posedge i_clk) begin
        t_pixel_answer got;
        t_pixel_answer want;
        if (!i_rst_n) begin
            o_errors        = 0;
            beams_loaded    = 0;
            next_angle      = '0;
            cfg_range_min   = 16'd0;
            cfg_range_max   = 16'd65535;
            cfg_inv_span    = 16'd1;
            cfg_start_angle = '0;
            cfg_angle_step  = 10'd1;
            cfg_height      = 13'd1;
            pixel_answers_q.delete();
            o_pending <= 0;
        end else begin
            // results first: a result never comes from a query accepted at the same edge
            if (i_valid) begin
                got = '{pixel: i_pixel, column_invalid: i_column_invalid};
                if (pixel_answers_q.size() == 0) begin
                    $error("unexpected result: pixel %0d column_invalid %0b",
                           got.pixel, got.column_invalid);
                    o_errors++;
                end else begin
                    want = pixel_answers_q.pop_front();
                    if (got.pixel !== want.pixel) begin
                        $error("pixel: expected %0d, got %0d", want.pixel, got.pixel);
                        o_errors++;
                    end
                    if (got.column_invalid !== want.column_invalid) begin
                        $error("column_invalid: expected %0b, got %0b",
                               want.column_invalid, got.column_invalid);
                        o_errors++;
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_RANGE_MIN:  cfg_range_min   = i_cfg_data[RANGE_W-1:0];
                    REG_RANGE_MAX:  cfg_range_max   = i_cfg_data[RANGE_W-1:0];
                    REG_INV_SPAN:   cfg_inv_span    = i_cfg_data[RANGE_W-1:0];
                    REG_START_ANG:  cfg_start_angle = i_cfg_data[ANGLE_W-1:0];
                    REG_ANGLE_STEP: cfg_angle_step  = i_cfg_data[ANGLE_W-1:0];
                    REG_HEIGHT:     cfg_height      = i_cfg_data[HEIGHT_W-1:0];
                    default: ;
                endcase
            end
            if (i_start && !i_busy) begin
                if (i_command == CMD_LOAD) begin
                    store_beam(i_range_mm, i_first_beam);
                end else begin
                    pixel_answers_q.push_back(predict_pixel(i_row, i_column));
                end
            end
            o_pending <= pixel_answers_q.size();
        end
    end

endmodule

>>> sim/tb_top.sv
// Testbench top: stimulus, configuration phases, watchdog and verdict.
`timescale 1ns / 1ps

module tb_top;
    import rscr_pkg::*;

    // Cycles with no transaction of any kind before the run is declared hung.
    // The slowest legal stretch is a long sender gap at 71% idle plus a
    // query in progress, far below this.
    localparam int STALL_LIMIT = 2000;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic                  command;
    logic [RANGE_W-1:0]    range_mm;
    logic                  first_beam;
    logic [ROW_W-1:0]      row;
    logic [COL_W-1:0]      column;
    logic                  valid;
    logic [PIXEL_W-1:0]    pixel;
    logic                  column_invalid;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    int mismatches;
    int pending;      // pixel answers still owed by the block
    int stall_cycles;
    int sender_idle_pct;

    // Testbench view of the scan, used only to aim queries and ranges
    int                  scan_beams;
    logic [RANGE_W-1:0]  min_now;
    logic [RANGE_W-1:0]  max_now;
    logic [HEIGHT_W-1:0] height_now;

    range_scan_column_raster dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .start            (start),
        .busy             (busy),
        .i_command        (command),
        .i_range_mm       (range_mm),
        .i_first_beam     (first_beam),
        .i_row            (row),
        .i_column         (column),
        .o_valid          (valid),
        .o_pixel          (pixel),
        .o_column_invalid (column_invalid),
        .i_cfg_we         (cfg_we),
        .i_cfg_idx        (cfg_idx),
        .i_cfg_data       (cfg_data)
    );

    rscr_scoreboard u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_start          (start),
        .i_busy           (busy),
        .i_command        (command),
        .i_range_mm       (range_mm),
        .i_first_beam     (first_beam),
        .i_row            (row),
        .i_column         (column),
        .i_valid          (valid),
        .i_pixel          (pixel),
        .i_column_invalid (column_invalid),
        .i_cfg_we         (cfg_we),
        .i_cfg_idx        (cfg_idx),
        .i_cfg_data       (cfg_data),
        .o_errors         (mismatches),
        .o_pending        (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: any accepted transaction (command, result, register write)
    // counts as progress.
    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || valid || cfg_we) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles == STALL_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // Write all six registers back to back; only called while the block is idle.
    task automatic configure(logic [15:0] rmin, logic [15:0] rmax, logic [15:0] inv,
                             logic [ANGLE_W-1:0] ang0, logic [ANGLE_W-1:0] step,
                             logic [HEIGHT_W-1:0] height);
        logic [CFG_IDX_W-1:0]  idx  [6];
        logic [CFG_DATA_W-1:0] vals [6];
        idx  = '{REG_RANGE_MIN, REG_RANGE_MAX, REG_INV_SPAN,
                 REG_START_ANG, REG_ANGLE_STEP, REG_HEIGHT};
        vals = '{rmin, rmax, inv, CFG_DATA_W'(ang0), CFG_DATA_W'(step),
                 CFG_DATA_W'(height)};
        foreach (idx[i]) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= idx[i];
            cfg_data <= vals[i];
            @(posedge clk);
        end
        cfg_we     <= 1'b0;
        min_now    = rmin;
        max_now    = rmax;
        height_now = height;
    endtask

    task automatic configure_random();
        int lo;
        lo = $urandom_range(0, 40000);
        configure(16'(lo), 16'(lo + $urandom_range(1, 65535 - lo)), 16'($urandom),
                  ANGLE_W'($urandom), ANGLE_W'($urandom),
                  HEIGHT_W'($urandom_range(1, 4096)));
    endtask

    // One command transaction: random sender gap, then hold start until taken.
    // busy read right after the edge is the value the block sampled.
    task automatic send(logic cmd, logic [RANGE_W-1:0] rng, logic first,
                        logic [ROW_W-1:0] r, logic [COL_W-1:0] c);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start      <= 1'b1;
        command    <= cmd;
        range_mm   <= rng;
        first_beam <= first;
        row        <= r;
        column     <= c;
        @(posedge clk);
        while (busy) @(posedge clk);
        if (cmd == CMD_LOAD) begin
            if (first) scan_beams = 1;
            else if (scan_beams < MAX_BEAMS) scan_beams++;
        end
    endtask

    // Wait until every pixel answer is in and the block is idle, then give a
    // load in flight time to finish (loads leave nothing to wait on).
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0 || busy) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Sender holds off until the block has answered everything outstanding
    task automatic hold_for_answers();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // Mostly inside the configured span, with the span ends, max range,
    // the 16-bit extremes and fully random values mixed in
    function automatic logic [RANGE_W-1:0] pick_range();
        int lo;
        int hi;
        lo = (min_now < max_now) ? min_now : max_now;
        hi = (min_now < max_now) ? max_now : min_now;
        case ($urandom_range(0, 9))
            0: return max_now;
            1: return min_now;
            2: return RANGE_W'($urandom);
            3: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            default: return RANGE_W'($urandom_range(lo, hi));
        endcase
    endfunction

    // Rows near the bar edges: stored values are at most about 1.0, so the
    // dark/blank boundary lies at or below the image height.
    function automatic logic [ROW_W-1:0] pick_row();
        int h;
        int top;
        h   = (height_now == 0) ? 1 : height_now;
        top = h + h / 4 + 1;
        if (top > 4095) top = 4095;
        if ($urandom_range(0, 5) == 0) return ROW_W'($urandom);
        return ROW_W'($urandom_range(0, top));
    endfunction

    function automatic logic [COL_W-1:0] pick_column();
        if (scan_beams == 0 || $urandom_range(0, 7) == 0) return COL_W'($urandom);
        if ($urandom_range(0, 15) == 0) return COL_W'(scan_beams);  // first unloaded
        return COL_W'($urandom_range(0, scan_beams - 1));
    endfunction

    // A well-formed scan: a first-beam load, then loads and queries interleaved.
    // About one item in sixteen is noise with every field random and counts
    // toward its own kind; restarts from noise are suppressed when the scan
    // has to fill up.
    task automatic run_scan(int n_loads, int n_queries, bit allow_restart);
        int   loads;
        int   queries;
        int   loads_left;
        int   queries_left;
        logic noise_cmd;
        send(CMD_LOAD, pick_range(), 1'b1, ROW_W'($urandom), COL_W'($urandom));
        loads   = 1;
        queries = 0;
        while (loads < n_loads || queries < n_queries) begin
            loads_left   = (loads < n_loads) ? n_loads - loads : 0;
            queries_left = (queries < n_queries) ? n_queries - queries : 0;
            if ($urandom_range(0, 15) == 0) begin
                noise_cmd = 1'($urandom);
                send(noise_cmd, RANGE_W'($urandom), allow_restart ? 1'($urandom) : 1'b0,
                     ROW_W'($urandom), COL_W'($urandom));
                if (noise_cmd == CMD_LOAD) loads++;
                else queries++;
            end else if ($urandom_range(0, loads_left + queries_left - 1) < loads_left) begin
                send(CMD_LOAD, pick_range(), 1'b0, ROW_W'($urandom), COL_W'($urandom));
                loads++;
            end else begin
                send(CMD_QUERY, RANGE_W'($urandom), 1'($urandom), pick_row(), pick_column());
                queries++;
            end
        end
    endtask

    initial begin
        rst_n           = 1'b0;
        start           = 1'b0;
        command         = CMD_LOAD;
        range_mm        = '0;
        first_beam      = 1'b0;
        row             = '0;
        column          = '0;
        cfg_we          = 1'b0;
        cfg_idx         = REG_RANGE_MIN;
        cfg_data        = '0;
        scan_beams      = 0;
        sender_idle_pct = 25;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // ---- Directed part ----
        // Half-turn step alternates cos +1 / -1 so signs are easy to follow.
        configure(16'd100, 16'd60000, 16'd65535, 10'd0, 10'd512, 13'd64);
        send(CMD_QUERY, '0, 1'b0, 12'd0, 10'd0);           // nothing loaded yet
        send(CMD_LOAD, 16'd60000, 1'b1, '0, '0);           // at max range, angle 0
        send(CMD_LOAD, 16'd0, 1'b0, '0, '0);               // below min, cos -1 -> small positive
        send(CMD_LOAD, 16'hFFFF, 1'b0, '0, '0);            // largest value
        send(CMD_LOAD, 16'd100, 1'b0, 12'hFFF, 10'h3FF);   // equals min; row/column ignored
        send(CMD_LOAD, 16'd30000, 1'b0, '0, '0);
        send(CMD_QUERY, '0, 1'b0, 12'd0, 10'd0);           // at max -> dark
        send(CMD_QUERY, '0, 1'b0, 12'd0, 10'd1);
        send(CMD_QUERY, '0, 1'b0, 12'd1, 10'd1);
        send(CMD_QUERY, '0, 1'b0, 12'd63, 10'd2);          // just under the bar top
        send(CMD_QUERY, '0, 1'b0, 12'd64, 10'd2);          // row at the height
        send(CMD_QUERY, '0, 1'b0, 12'hFFF, 10'd2);         // far past the height
        send(CMD_QUERY, '0, 1'b0, 12'd0, 10'd3);           // zero value -> blank
        send(CMD_QUERY, 16'hFFFF, 1'b1, 12'd0, 10'd4);     // range/first ignored on query
        send(CMD_QUERY, '0, 1'b0, 12'd0, 10'd5);           // first unloaded column
        send(CMD_QUERY, '0, 1'b0, 12'hFFF, 10'h3FF);
        send(CMD_LOAD, 16'd0, 1'b1, '0, '0);               // restart; negative value at angle 0
        send(CMD_QUERY, '0, 1'b0, 12'd0, 10'd0);
        send(CMD_QUERY, '0, 1'b0, 12'd0, 10'd1);           // loaded only in the last scan -> invalid now
        drain();

        // ---- Sender idles 25% ----
        for (int k = 0; k < 3; k++) begin
            if (k == 1) configure(16'd0, 16'd65535, 16'd65535, 10'd1023, 10'd1, 13'd4096);
            else configure_random();
            if ($urandom_range(0, 1)) hold_for_answers();
            run_scan(4, 4, 1'b1);
            hold_for_answers();                            // sender pressure mid-phase
            run_scan(3, 3, 1'b1);
            drain();
        end

        // ---- Sender idles 71% ----
        sender_idle_pct = 71;
        for (int k = 0; k < 3; k++) begin
            if (k == 0) configure(16'd65535, 16'd0, 16'd0, 10'd0, 10'd0, 13'd0);
            else if (k == 1) configure(16'd0, 16'd65535, 16'($urandom), ANGLE_W'($urandom),
                                       ANGLE_W'($urandom), 13'd8191);
            else configure_random();
            if ($urandom_range(0, 1)) hold_for_answers();
            run_scan(4, 6, 1'b1);
            drain();
        end

        // ---- No idling: one scan filled to capacity, a few loads past it ----
        sender_idle_pct = 0;
        configure_random();
        run_scan(MAX_BEAMS + 2, 8, 1'b0);
        for (int k = 0; k < 8; k++) begin
            send(CMD_QUERY, RANGE_W'($urandom), 1'($urandom), pick_row(),
                 (k == 0) ? 10'h3FF : pick_column());
        end
        drain();

        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
